>>> rtl/tsrl_pkg.sv
// Shared types, codes and stamp-widening tables for the timestamp range log table.
package tsrl_pkg;

  localparam int STAMP_W = 40;
  localparam int ID_W = 31;
  localparam int GRAN_W = 3;
  localparam int STATUS_W = 2;
  localparam int TABLE_DEPTH_DEF = 64;

  localparam logic MODE_PUT = 1'b0;
  localparam logic MODE_RETRIEVE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_STORED = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_MATCH = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_NOMATCH = 2'd3;

  localparam logic [GRAN_W-1:0] GRAN_SECOND = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_SCAN_RD,
    ST_SCAN_CMP
  } tsrl_state_t;

  // Result of the shared stamp comparator.
  typedef struct packed {
    logic above;  // stamp > upper key
    logic below;  // stamp < lower key
  } tsrl_cmp_t;

  // Fields below the granularity, indexed by granularity.
  localparam logic [STAMP_W-1:0] LOW_MASK [0:5] = '{
    40'h0003FF_FFFF, 40'h00003FFFFF, 40'h000001FFFF,
    40'h0000000FFF, 40'h000000003F, 40'h0000000000
  };

  // Month 1, day 1 where those fields are filled.
  localparam logic [STAMP_W-1:0] MIN_FILL [0:5] = '{
    (40'd1 << 22) | (40'd1 << 17), (40'd1 << 17),
    40'd0, 40'd0, 40'd0, 40'd0
  };

  // Month 12, day 31, 23:59:59 where those fields are filled.
  localparam logic [STAMP_W-1:0] MAX_FILL [0:5] = '{
    (40'd12 << 22) | (40'd31 << 17) | (40'd23 << 12) | (40'd59 << 6) | 40'd59,
    (40'd31 << 17) | (40'd23 << 12) | (40'd59 << 6) | 40'd59,
    (40'd23 << 12) | (40'd59 << 6) | 40'd59,
    (40'd59 << 6) | 40'd59,
    40'd59,
    40'd0
  };

  function automatic logic [GRAN_W-1:0] gran_clamp(input logic [GRAN_W-1:0] g);
    return (g > GRAN_SECOND) ? GRAN_SECOND : g;
  endfunction

  function automatic logic [STAMP_W-1:0] range_start(input logic [STAMP_W-1:0] t,
                                                     input logic [GRAN_W-1:0] g);
    logic [GRAN_W-1:0] gc;
    gc = gran_clamp(g);
    return (t & ~LOW_MASK[gc]) | MIN_FILL[gc];
  endfunction

  function automatic logic [STAMP_W-1:0] range_end(input logic [STAMP_W-1:0] t,
                                                   input logic [GRAN_W-1:0] g);
    logic [GRAN_W-1:0] gc;
    gc = gran_clamp(g);
    return (t & ~LOW_MASK[gc]) | MAX_FILL[gc];
  endfunction

endpackage

>>> rtl/tsrl_mem.sv
// Entry store: one write port and one registered read port.
module tsrl_mem import tsrl_pkg::*; #(
  parameter int DEPTH = TABLE_DEPTH_DEF,
  parameter int AW = 6
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [AW-1:0]           waddr,
  input  logic [STAMP_W+ID_W-1:0] wdata,
  input  logic [AW-1:0]           raddr,
  output logic [STAMP_W+ID_W-1:0] rdata
);

  logic [STAMP_W+ID_W-1:0] mem [0:DEPTH-1];
  logic [STAMP_W+ID_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/tsrl_cmp.sv
// Shared stamp comparator used by both the insertion shift and the range scan.
module tsrl_cmp import tsrl_pkg::*; (
  input  logic [STAMP_W-1:0] stamp,
  input  logic [STAMP_W-1:0] key_hi,
  input  logic [STAMP_W-1:0] key_lo,
  output tsrl_cmp_t          res
);

  assign res.above = (stamp > key_hi);
  assign res.below = (stamp < key_lo);

endmodule

>>> rtl/timestamp_range_log_table.sv
// Top level: sequencer for the time-sorted log table.
//
// A put on a full table answers in the cycle after the accepting edge and busy never
// rises. Any other put walks down past the stored entries with a later stamp, each
// read and moved up one slot through the single memory read port; when every stored
// entry is later the walk ends at slot 0. A retrieve reads the entries in order, one
// read and one compare on the shared comparator per entry, and stops at the first
// entry past the end stamp or when it has read all stored entries. busy is high from
// the cycle after the accepting edge and falls in the cycle that shows the last
// result; results come as one-cycle out_valid strobes that cannot be held off, the
// last one flagged by out_last.
module timestamp_range_log_table import tsrl_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_mode,
  input  logic [ID_W-1:0]     in_log_id,
  input  logic [STAMP_W-1:0]  in_time_a,
  input  logic [STAMP_W-1:0]  in_time_b,
  input  logic [GRAN_W-1:0]   in_granularity,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic [ID_W-1:0]     out_found_id,
  output logic                out_last
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  tsrl_state_t state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       pos_r, pos_nxt;
  logic [STAMP_W-1:0]  key_hi_r, key_hi_nxt;
  logic [STAMP_W-1:0]  key_lo_r, key_lo_nxt;
  logic [ID_W-1:0]     new_id_r, new_id_nxt;
  logic [ID_W-1:0]     hold_id_r, hold_id_nxt;
  logic                have_r, have_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [ID_W-1:0]     out_found_id_r, out_found_id_nxt;
  logic                out_last_r, out_last_nxt;

  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic [STAMP_W+ID_W-1:0] mem_wdata;
  logic [AW-1:0]           mem_raddr;
  logic [STAMP_W+ID_W-1:0] mem_rdata;
  tsrl_cmp_t               cmp;

  logic accept;
  logic full;
  logic [CW-1:0] pos_dec;

  assign accept = start && (state_r == ST_IDLE);
  assign full = (count_r >= CW'(TABLE_DEPTH));
  assign pos_dec = pos_r - CW'(1);

  tsrl_mem #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  tsrl_cmp u_cmp (
    .stamp  (mem_rdata[STAMP_W+ID_W-1:ID_W]),
    .key_hi (key_hi_r),
    .key_lo (key_lo_r),
    .res    (cmp)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_mode == MODE_RETRIEVE) begin
            state_nxt = ST_SCAN_RD;
          end else if (!full) begin
            state_nxt = ST_INS_RD;
          end
        end
      end
      ST_INS_RD: begin
        state_nxt = (pos_r == '0) ? ST_IDLE : ST_INS_CMP;
      end
      ST_INS_CMP: begin
        state_nxt = cmp.above ? ST_INS_RD : ST_IDLE;
      end
      ST_SCAN_RD: begin
        state_nxt = (pos_r == count_r) ? ST_IDLE : ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        state_nxt = cmp.above ? ST_IDLE : ST_SCAN_RD;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    pos_nxt = pos_r;
    key_hi_nxt = key_hi_r;
    key_lo_nxt = key_lo_r;
    new_id_nxt = new_id_r;
    hold_id_nxt = hold_id_r;
    have_nxt = have_r;
    out_valid_nxt = 1'b0;
    out_status_nxt = out_status_r;
    out_found_id_nxt = out_found_id_r;
    out_last_nxt = out_last_r;
    mem_we = 1'b0;
    mem_waddr = pos_r[AW-1:0];
    mem_wdata = {key_hi_r, new_id_r};
    mem_raddr = pos_r[AW-1:0];
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_mode == MODE_RETRIEVE) begin
            key_lo_nxt = range_start(in_time_a, in_granularity);
            key_hi_nxt = range_end(in_time_b, in_granularity);
            pos_nxt = '0;
            have_nxt = 1'b0;
          end else if (full) begin
            out_valid_nxt = 1'b1;
            out_status_nxt = STATUS_FULL;
            out_found_id_nxt = '0;
            out_last_nxt = 1'b1;
          end else begin
            key_hi_nxt = in_time_a;
            new_id_nxt = in_log_id;
            pos_nxt = count_r;
          end
        end
      end
      ST_INS_RD: begin
        mem_raddr = pos_dec[AW-1:0];
        if (pos_r == '0) begin
          mem_we = 1'b1;
          count_nxt = count_r + CW'(1);
          out_valid_nxt = 1'b1;
          out_status_nxt = STATUS_STORED;
          out_found_id_nxt = '0;
          out_last_nxt = 1'b1;
        end
      end
      ST_INS_CMP: begin
        mem_we = 1'b1;
        if (cmp.above) begin
          // Later stamp: move the entry up one slot and keep walking down.
          mem_wdata = mem_rdata;
          pos_nxt = pos_dec;
        end else begin
          count_nxt = count_r + CW'(1);
          out_valid_nxt = 1'b1;
          out_status_nxt = STATUS_STORED;
          out_found_id_nxt = '0;
          out_last_nxt = 1'b1;
        end
      end
      ST_SCAN_RD: begin
        if (pos_r == count_r) begin
          out_valid_nxt = 1'b1;
          out_status_nxt = have_r ? STATUS_MATCH : STATUS_NOMATCH;
          out_found_id_nxt = have_r ? hold_id_r : '0;
          out_last_nxt = 1'b1;
        end
      end
      ST_SCAN_CMP: begin
        // A match is held back until the next match or the end of the scan, so the final one can carry the last flag.
        if (cmp.above) begin
          out_valid_nxt = 1'b1;
          out_status_nxt = have_r ? STATUS_MATCH : STATUS_NOMATCH;
          out_found_id_nxt = have_r ? hold_id_r : '0;
          out_last_nxt = 1'b1;
        end else begin
          pos_nxt = pos_r + CW'(1);
          if (!cmp.below) begin
            if (have_r) begin
              out_valid_nxt = 1'b1;
              out_status_nxt = STATUS_MATCH;
              out_found_id_nxt = hold_id_r;
              out_last_nxt = 1'b0;
            end
            hold_id_nxt = mem_rdata[ID_W-1:0];
            have_nxt = 1'b1;
          end
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      have_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      have_r <= have_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    key_hi_r <= key_hi_nxt;
    key_lo_r <= key_lo_nxt;
    new_id_r <= new_id_nxt;
    hold_id_r <= hold_id_nxt;
    out_status_r <= out_status_nxt;
    out_found_id_r <= out_found_id_nxt;
    out_last_r <= out_last_nxt;
  end

  assign busy = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_found_id = out_found_id_r;
  assign out_last = out_last_r;

endmodule

>>> rtl/tsrl_checker.sv
// Port-level checker for the log table, bound to the top level.
module tsrl_checker import tsrl_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input logic [STATUS_W-1:0] out_status,
  input logic [ID_W-1:0]     out_found_id,
  input logic                out_last
);

  // An accepted beat either keeps the block busy or answers in the next cycle.
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted beat produced neither busy nor a result");

  // A put answers with a single, final result.
  a_put_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == STATUS_STORED || out_status == STATUS_FULL)) |-> out_last)
    else $error("put result without last flag");

  // Only a matching result carries an id.
  a_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STATUS_MATCH) |-> (out_found_id == '0))
    else $error("nonzero id on a result that is not a match");

  // The final result frees the block; earlier ones come while it is still busy.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == !busy))
    else $error("last flag disagrees with busy");

endmodule

bind timestamp_range_log_table tsrl_checker u_tsrl_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .out_valid    (out_valid),
  .out_status   (out_status),
  .out_found_id (out_found_id),
  .out_last     (out_last)
);

>>> sim/tb.sv
// Self-checking testbench for the time-sorted log table: puts, range retrieves, table full.
module tb import tsrl_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [GRAN_W-1:0] GRAN_YEAR = 3'd0;
  localparam logic [GRAN_W-1:0] GRAN_MONTH = 3'd1;
  localparam logic [GRAN_W-1:0] GRAN_DAY = 3'd2;
  localparam logic [GRAN_W-1:0] GRAN_HOUR = 3'd3;
  localparam logic [GRAN_W-1:0] GRAN_MINUTE = 3'd4;
  localparam int RANDOM_REQS = 258;

  typedef struct {
    logic                mode;
    logic [ID_W-1:0]     log_id;
    logic [STAMP_W-1:0]  time_a;
    logic [STAMP_W-1:0]  time_b;
    logic [GRAN_W-1:0]   gran;
    bit                  drain_first;
  } request_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     found_id;
    logic                last;
  } reply_t;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic                in_mode = MODE_PUT;
  logic [ID_W-1:0]     in_log_id = '0;
  logic [STAMP_W-1:0]  in_time_a = '0;
  logic [STAMP_W-1:0]  in_time_b = '0;
  logic [GRAN_W-1:0]   in_granularity = '0;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [ID_W-1:0]     out_found_id;
  logic                out_last;

  request_t           request_q[$];
  reply_t             reply_q[$];
  logic [STAMP_W-1:0] put_stamps[$];
  request_t           cur_req;
  reply_t             want;
  int                 n_accepted = 0;
  int                 n_requests = 0;
  int                 n_errors = 0;
  int                 idle_left = 0;
  int                 burst_left = 0;

  // Shadow copy of the log table.
  logic [STAMP_W-1:0] log_stamp[TABLE_DEPTH_DEF];
  logic [ID_W-1:0]    log_ident[TABLE_DEPTH_DEF];
  int unsigned        log_fill = 0;

  timestamp_range_log_table #(.TABLE_DEPTH(TABLE_DEPTH_DEF)) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_mode(in_mode),
    .in_log_id(in_log_id),
    .in_time_a(in_time_a),
    .in_time_b(in_time_b),
    .in_granularity(in_granularity),
    .out_valid(out_valid),
    .out_status(out_status),
    .out_found_id(out_found_id),
    .out_last(out_last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [STAMP_W-1:0] pack_stamp(input int unsigned yr, mo, dy, hr, mi, se);
    return {yr[13:0], mo[3:0], dy[4:0], hr[4:0], mi[5:0], se[5:0]};
  endfunction

  function automatic logic [STAMP_W-1:0] raw_stamp();
    logic [STAMP_W-1:0] r;
    r[31:0] = $urandom();
    r[39:32] = 8'($urandom());
    return r;
  endfunction

  function automatic void push_reply(input logic [STATUS_W-1:0] st, input logic [ID_W-1:0] id,
                                     input logic lst);
    reply_t r;
    r.status = st;
    r.found_id = id;
    r.last = lst;
    reply_q = {reply_q, r};
  endfunction

  // Insert after any entry with an equal stamp, or report the table full.
  function automatic void log_put(input logic [ID_W-1:0] id, input logic [STAMP_W-1:0] ts);
    int unsigned pos;
    if (log_fill >= TABLE_DEPTH_DEF) begin
      push_reply(STATUS_FULL, '0, 1'b1);
      return;
    end
    pos = log_fill;
    while (pos > 0 && log_stamp[pos-1] > ts) begin
      log_stamp[pos] = log_stamp[pos-1];
      log_ident[pos] = log_ident[pos-1];
      pos--;
    end
    log_stamp[pos] = ts;
    log_ident[pos] = id;
    log_fill++;
    push_reply(STATUS_STORED, '0, 1'b1);
  endfunction

  function automatic void log_range(input logic [STAMP_W-1:0] ta, input logic [STAMP_W-1:0] tb,
                                    input logic [GRAN_W-1:0] gran);
    logic [GRAN_W-1:0]  g;
    int unsigned        low_bits;
    logic [STAMP_W-1:0] lo_fill, hi_fill, keep, lo_key, hi_key;
    int                 hits;
    g = (gran > GRAN_SECOND) ? GRAN_SECOND : gran;
    lo_fill = '0;
    case (g)
      GRAN_YEAR: begin
        low_bits = 26;
        lo_fill = pack_stamp(0, 1, 1, 0, 0, 0);
        hi_fill = pack_stamp(0, 12, 31, 23, 59, 59);
      end
      GRAN_MONTH: begin
        low_bits = 22;
        lo_fill = pack_stamp(0, 0, 1, 0, 0, 0);
        hi_fill = pack_stamp(0, 0, 31, 23, 59, 59);
      end
      GRAN_DAY: begin
        low_bits = 17;
        hi_fill = pack_stamp(0, 0, 0, 23, 59, 59);
      end
      GRAN_HOUR: begin
        low_bits = 12;
        hi_fill = pack_stamp(0, 0, 0, 0, 59, 59);
      end
      GRAN_MINUTE: begin
        low_bits = 6;
        hi_fill = pack_stamp(0, 0, 0, 0, 0, 59);
      end
      default: begin
        low_bits = 0;
        hi_fill = '0;
      end
    endcase
    keep = {STAMP_W{1'b1}} << low_bits;
    lo_key = (ta & keep) | lo_fill;
    hi_key = (tb & keep) | hi_fill;
    hits = 0;
    for (int unsigned i = 0; i < log_fill; i++) begin
      if (log_stamp[i] > hi_key) break;
      if (log_stamp[i] >= lo_key) begin
        push_reply(STATUS_MATCH, log_ident[i], 1'b0);
        hits++;
      end
    end
    if (hits == 0) push_reply(STATUS_NOMATCH, '0, 1'b1);
    else reply_q[$].last = 1'b1;
  endfunction

  // Mostly short gaps, a few long ones, and now and then a burst with none.
  function automatic int pick_gap();
    int roll;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 5) burst_left = $urandom_range(10, 30);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Calendar stamps from a narrow span of years so that ranges hit, plus repeats and raw bits.
  function automatic logic [STAMP_W-1:0] pick_stamp();
    int roll;
    int unsigned yr, mo, dy, hr, mi, se;
    roll = $urandom_range(0, 99);
    if (roll < 10) return raw_stamp();
    if (roll < 30 && put_stamps.size() != 0)
      return put_stamps[$urandom_range(0, put_stamps.size() - 1)];
    yr = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 16383) : $urandom_range(2020, 2022);
    mo = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 12);
    dy = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 31);
    hr = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 23);
    mi = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 59);
    se = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 59);
    return pack_stamp(yr, mo, dy, hr, mi, se);
  endfunction

  // Fields a put ignores carry random values.
  task automatic queue_put(input logic [ID_W-1:0] id, input logic [STAMP_W-1:0] ts,
                           input bit drain);
    request_t r;
    r.mode = MODE_PUT;
    r.log_id = id;
    r.time_a = ts;
    r.time_b = raw_stamp();
    r.gran = GRAN_W'($urandom());
    r.drain_first = drain;
    request_q = {request_q, r};
    put_stamps = {put_stamps, ts};
  endtask

  task automatic queue_range(input logic [STAMP_W-1:0] ta, input logic [STAMP_W-1:0] tb,
                             input logic [GRAN_W-1:0] gran, input bit drain);
    request_t r;
    r.mode = MODE_RETRIEVE;
    r.log_id = ID_W'($urandom());
    r.time_a = ta;
    r.time_b = tb;
    r.gran = gran;
    r.drain_first = drain;
    request_q = {request_q, r};
  endtask

  initial begin : stimulus
    logic [STAMP_W-1:0] s0, s1, ta, tb, tmp;
    s0 = pack_stamp(2021, 6, 15, 12, 30, 44);
    s1 = pack_stamp(2021, 6, 15, 12, 30, 45);

    queue_range('0, '1, GRAN_SECOND, 1'b0);
    queue_put('0, '0, 1'b0);
    queue_put('1, '1, 1'b0);
    queue_put(31'd5, s1, 1'b0);
    queue_put(31'd6, s1, 1'b0);
    queue_put(31'd7, s0, 1'b0);
    queue_put(31'd8, pack_stamp(2021, 6, 30, 23, 59, 59), 1'b0);
    queue_put(31'd9, pack_stamp(2021, 7, 1, 0, 0, 0), 1'b0);
    queue_put(31'd10, pack_stamp(2021, 15, 31, 31, 63, 63), 1'b0);
    queue_range('0, '1, GRAN_SECOND, 1'b1);
    for (int g = 0; g < 8; g++) queue_range(s1, s1, GRAN_W'(g), 1'b0);
    // Start after end, at fine and at coarse granularity.
    queue_range(s1, s0, GRAN_SECOND, 1'b0);
    queue_range(pack_stamp(2022, 1, 1, 0, 0, 0), pack_stamp(2021, 12, 31, 0, 0, 0),
                GRAN_YEAR, 1'b0);
    queue_range('1, '1, GRAN_YEAR, 1'b0);
    queue_range('0, '0, GRAN_YEAR, 1'b0);

    for (int k = 0; k < RANDOM_REQS; k++) begin
      if ($urandom_range(0, 99) < 35) begin
        queue_put(ID_W'($urandom()), pick_stamp(), (k % 60) == 0);
      end else begin
        ta = pick_stamp();
        tb = pick_stamp();
        if ($urandom_range(0, 9) < 8 && ta > tb) begin
          tmp = ta;
          ta = tb;
          tb = tmp;
        end
        queue_range(ta, tb,
                    GRAN_W'(($urandom_range(0, 9) == 0) ? $urandom_range(6, 7)
                                                        : $urandom_range(0, 5)),
                    (k % 60) == 0);
      end
    end
    n_requests = request_q.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    wait (n_accepted == n_requests);
    wait (reply_q.size() == 0);
    repeat (20) @(posedge clk);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Sender: holds start with a request until it is taken, then idles for a random gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        if (cur_req.mode == MODE_PUT) log_put(cur_req.log_id, cur_req.time_a);
        else log_range(cur_req.time_a, cur_req.time_b, cur_req.gran);
        n_accepted++;
        idle_left = pick_gap();
        if (idle_left == 0 && request_q.size() != 0 &&
            (!request_q[0].drain_first || reply_q.size() == 0)) begin
          cur_req = request_q.pop_front();
          in_mode <= cur_req.mode;
          in_log_id <= cur_req.log_id;
          in_time_a <= cur_req.time_a;
          in_time_b <= cur_req.time_b;
          in_granularity <= cur_req.gran;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end else if (!start) begin
        if (idle_left > 0) idle_left--;
        if (idle_left == 0 && request_q.size() != 0 &&
            (!request_q[0].drain_first || reply_q.size() == 0)) begin
          cur_req = request_q.pop_front();
          in_mode <= cur_req.mode;
          in_log_id <= cur_req.log_id;
          in_time_a <= cur_req.time_a;
          in_time_b <= cur_req.time_b;
          in_granularity <= cur_req.gran;
          start <= 1'b1;
        end else begin
          // The block must ignore whatever sits on the inputs while start is low.
          in_mode <= 1'($urandom_range(0, 1));
          in_log_id <= ID_W'($urandom());
          in_time_a <= raw_stamp();
          in_time_b <= raw_stamp();
          in_granularity <= GRAN_W'($urandom());
        end
      end
    end
  end

  // Results cannot be held off, so every strobe is checked on the edge that ends it.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (reply_q.size() == 0) begin
        $display("%0t: result with none expected: status %0d id %0d last %0d",
                 $time, out_status, out_found_id, out_last);
        n_errors++;
      end else begin
        want = reply_q.pop_front();
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d, actual %0d", $time, want.status, out_status);
          n_errors++;
        end
        if (out_found_id !== want.found_id) begin
          $display("%0t: found_id expected %0d, actual %0d",
                   $time, want.found_id, out_found_id);
          n_errors++;
        end
        if (out_last !== want.last) begin
          $display("%0t: last expected %0d, actual %0d", $time, want.last, out_last);
          n_errors++;
        end
      end
    end
  end

endmodule
